@@ rtl/drhaf_pkg.sv @@
package drhaf_pkg;

   localparam int WIN_LEN  = 32;
   localparam int FILL_W   = $clog2(WIN_LEN + 1);
   localparam int ROT_OUT  = WIN_LEN % 64;
   localparam int ROT_BACK = (64 - ROT_OUT) % 64;

   localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] START_LAG  = 32'(WIN_LEN - 1);

   localparam logic [63:0] SM_GOLDEN         = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] SM_MIX_A          = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] SM_MIX_B          = 64'h94d0_49bb_1331_11eb;
   localparam logic [63:0] SEED_PRIMARY      = 64'h46a7_c15d_3b92_e801;
   localparam logic [63:0] SEED_SECONDARY    = 64'hd1b5_4a32_d192_ed03;
   localparam logic [63:0] ANCHOR_MASK_RESET = 64'd63;

   typedef logic [255:0][63:0] table_type;

   typedef struct packed {
      logic step;
      logic drop_old;
      logic restart;
   } roll_ctrl_type;

   // splitmix64 sequence, evaluated at elaboration only
   function automatic table_type build_table(input logic [63:0] seed);
      table_type   t;
      logic [63:0] s;
      logic [63:0] z;
      s = seed;
      for (int i = 0; i < 256; i++) begin
         s = s + SM_GOLDEN;
         z = s;
         z = (z ^ (z >> 30)) * SM_MIX_A;
         z = (z ^ (z >> 27)) * SM_MIX_B;
         t[i] = z ^ (z >> 31);
      end
      return t;
   endfunction

   localparam table_type PRIMARY_TABLE   = build_table(SEED_PRIMARY);
   localparam table_type SECONDARY_TABLE = build_table(SEED_SECONDARY);

   function automatic logic [63:0] rotl1(input logic [63:0] v);
      return {v[62:0], v[63]};
   endfunction

   // rotate by the window length mod 64
   function automatic logic [63:0] rot_window(input logic [63:0] v);
      return (v << ROT_OUT) | (v >> ROT_BACK);
   endfunction

endpackage

@@ rtl/drhaf_roll.sv @@
module drhaf_roll (
   input  logic                    clock,
   input  logic                    reset,
   input  drhaf_pkg::roll_ctrl_type ctrl,
   input  logic [7:0]              in_byte,
   input  logic [7:0]              out_byte,
   output logic [63:0]             next_primary,
   output logic [63:0]             next_secondary
);
   import drhaf_pkg::*;

   logic [63:0] primary_ff, primary_in;
   logic [63:0] secondary_ff, secondary_in;
   logic [63:0] cancel_primary, cancel_secondary;

   always_comb begin
      cancel_primary   = ctrl.drop_old ? rot_window(PRIMARY_TABLE[out_byte]) : 64'd0;
      cancel_secondary = ctrl.drop_old ? rot_window(SECONDARY_TABLE[out_byte]) : 64'd0;
      next_primary     = rotl1(primary_ff) ^ PRIMARY_TABLE[in_byte] ^ cancel_primary;
      next_secondary   = rotl1(secondary_ff) ^ SECONDARY_TABLE[in_byte] ^ cancel_secondary;
   end

   always_comb begin
      primary_in   = primary_ff;
      secondary_in = secondary_ff;
      if (ctrl.step) begin
         // end of stream: result still carries the hash, state starts over
         primary_in   = ctrl.restart ? 64'd0 : next_primary;
         secondary_in = ctrl.restart ? 64'd0 : next_secondary;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primary_ff   <= 64'd0;
         secondary_ff <= 64'd0;
      end else begin
         primary_ff   <= primary_in;
         secondary_ff <= secondary_in;
      end
   end

endmodule

@@ rtl/dual_rolling_hash_anchor_finder_top.sv @@
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | req_data_byte, req_end_of_stream
// rsp     | out       | rsp_valid / rsp_ready  | rsp_window_start, rsp_hash_primary,
//         |           |                        | rsp_hash_secondary, rsp_is_anchor,
//         |           |                        | rsp_final_window
// csr     | in        | csr_valid / csr_ready  | csr_anchor_mask
//
// one byte per cycle unless rsp stalls; a byte that completes a window yields a result
// (input register, then table lookup, rotate and xor into the result register)
// the hash recurrence closes through the state registers and the two 256-word constant tables
// synchronous reset clears hashes, fill count, offset and valids; mask resets to 63
// csr_ready is always high; a stalled rsp holds the result and stops the input stage
module dual_rolling_hash_anchor_finder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_window_start,
   output logic [63:0] rsp_hash_primary,
   output logic [63:0] rsp_hash_secondary,
   output logic        rsp_is_anchor,
   output logic        rsp_final_window,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_anchor_mask
);
   import drhaf_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff;
   logic              s1_eos_ff;
   logic [7:0]        window_ff [WIN_LEN];
   logic [7:0]        window_in [WIN_LEN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       offset_ff, offset_in;
   logic [63:0]       mask_ff;
   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_start_ff;
   logic [63:0]       out_primary_ff;
   logic [63:0]       out_secondary_ff;
   logic              out_anchor_ff;
   logic              out_final_ff;

   logic              s1_go;
   logic              full;
   logic              emits;
   logic [31:0]       start;
   logic [63:0]       next_primary, next_secondary;
   roll_ctrl_type     roll_ctrl;

   assign s1_go     = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign csr_ready = 1'b1;

   assign full  = (fill_ff == FILL_W'(WIN_LEN));
   // window is full once this byte is in
   assign emits = full || (fill_ff == FILL_W'(WIN_LEN - 1));
   assign start = (offset_ff >= START_LAG) ? (offset_ff - START_LAG) : 32'd0;

   assign roll_ctrl.step     = s1_go;
   assign roll_ctrl.drop_old = full;
   assign roll_ctrl.restart  = s1_eos_ff;

   drhaf_roll u_roll (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (roll_ctrl),
      .in_byte        (s1_byte_ff),
      .out_byte       (window_ff[0]),
      .next_primary   (next_primary),
      .next_secondary (next_secondary)
   );

   // shift line; oldest byte sits at the head once the window is full
   always_comb begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      window_in[WIN_LEN - 1] = s1_byte_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      fill_in   = fill_ff;
      offset_in = offset_ff;
      if (s1_go) begin
         if (s1_eos_ff) begin
            fill_in   = '0;
            offset_in = 32'd0;
         end else begin
            fill_in   = full ? fill_ff : fill_ff + FILL_W'(1);
            offset_in = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + 32'd1;
         end
      end

      out_valid_in = out_valid_ff;
      if (s1_go) begin
         out_valid_in = emits;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         offset_ff    <= 32'd0;
         mask_ff      <= ANCHOR_MASK_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fill_ff      <= fill_in;
         offset_ff    <= offset_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_anchor_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_eos_ff  <= req_end_of_stream;
      end
      if (s1_go) begin
         window_ff <= window_in;
      end
      if (s1_go && emits) begin
         out_start_ff     <= start;
         out_primary_ff   <= next_primary;
         out_secondary_ff <= next_secondary;
         out_anchor_ff    <= ((next_primary & mask_ff) == 64'd0);
         out_final_ff     <= s1_eos_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_window_start   = out_start_ff;
   assign rsp_hash_primary   = out_primary_ff;
   assign rsp_hash_secondary = out_secondary_ff;
   assign rsp_is_anchor      = out_anchor_ff;
   assign rsp_final_window   = out_final_ff;

endmodule

@@ rtl/drhaf_checker.sv @@
module drhaf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_window_start,
   input logic [63:0] rsp_hash_primary,
   input logic        rsp_is_anchor,
   input logic        rsp_final_window,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [63:0] csr_anchor_mask
);
   import drhaf_pkg::*;

   localparam logic [31:0] START_SAT = OFFSET_MAX - START_LAG;

   logic [63:0] mask_ff;
   logic        seen_ff;
   logic        prev_final_ff;
   logic [31:0] prev_start_ff;
   logic        out_acc;

   assign out_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= ANCHOR_MASK_RESET;
         seen_ff       <= 1'b0;
         prev_final_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_anchor_mask;
         end
         if (out_acc) begin
            seen_ff       <= 1'b1;
            prev_final_ff <= rsp_final_window;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_acc) begin
         prev_start_ff <= rsp_window_start;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_primary))
      else $error("stalled result changed");

   a_anchor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_anchor == ((rsp_hash_primary & mask_ff) == 64'd0))
      else $error("anchor flag disagrees with masked hash");

   a_new_stream: assert property (@(posedge clock) disable iff (reset)
      out_acc && seen_ff && prev_final_ff |-> rsp_window_start == 32'd0)
      else $error("new stream does not start at offset zero");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      out_acc && seen_ff && !prev_final_ff |->
         (rsp_window_start == prev_start_ff + 32'd1) ||
         (rsp_window_start == START_SAT && prev_start_ff == START_SAT))
      else $error("window start did not advance by one");

endmodule

bind dual_rolling_hash_anchor_finder_top drhaf_checker u_drhaf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_window_start (rsp_window_start),
   .rsp_hash_primary (rsp_hash_primary),
   .rsp_is_anchor    (rsp_is_anchor),
   .rsp_final_window (rsp_final_window),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready),
   .csr_anchor_mask  (csr_anchor_mask)
);

@@ tb/sv/dual_rolling_hash_anchor_finder_top_tb.sv @@
module dual_rolling_hash_anchor_finder_top_tb;
   import drhaf_pkg::*;

   typedef struct packed {
      logic [31:0] start;
      logic [63:0] primary;
      logic [63:0] secondary;
      logic        anchor;
      logic        last;
   } window_result_type;

   class anchor_window_predictor;
      logic [63:0]       primary_words [256];
      logic [63:0]       secondary_words [256];
      logic [7:0]        win_bytes [WIN_LEN];
      logic [63:0]       primary_hash;
      logic [63:0]       secondary_hash;
      int unsigned       held;
      logic [31:0]       next_offset;
      logic [63:0]       mask;
      window_result_type pending_windows [$];
      int                errors;

      function new();
         logic [63:0] s1;
         logic [63:0] s2;
         s1 = SEED_PRIMARY;
         s2 = SEED_SECONDARY;
         for (int i = 0; i < 256; i++) begin
            s1 = s1 + SM_GOLDEN;
            s2 = s2 + SM_GOLDEN;
            primary_words[i]   = scramble(s1);
            secondary_words[i] = scramble(s2);
         end
         mask   = ANCHOR_MASK_RESET;
         errors = 0;
         restart();
      endfunction

      function logic [63:0] scramble(logic [63:0] z);
         z = (z ^ (z >> 30)) * SM_MIX_A;
         z = (z ^ (z >> 27)) * SM_MIX_B;
         return z ^ (z >> 31);
      endfunction

      function logic [63:0] rotl(logic [63:0] v, int amount);
         amount = amount % 64;
         if (amount == 0) return v;
         return (v << amount) | (v >> (64 - amount));
      endfunction

      function void restart();
         foreach (win_bytes[i]) win_bytes[i] = 8'h00;
         primary_hash   = '0;
         secondary_hash = '0;
         held           = 0;
         next_offset    = '0;
      endfunction

      function void set_mask(logic [63:0] m);
         mask = m;
      endfunction

      function int pending();
         return pending_windows.size();
      endfunction

      function void take_byte(logic [7:0] b, logic eos);
         logic [63:0]       h1;
         logic [63:0]       h2;
         logic [31:0]       here;
         logic [7:0]        oldest;
         window_result_type r;
         here = next_offset;
         h1 = rotl(primary_hash, 1) ^ primary_words[b];
         h2 = rotl(secondary_hash, 1) ^ secondary_words[b];
         if (held >= WIN_LEN) begin
            oldest = win_bytes[0];
            h1 ^= rotl(primary_words[oldest], WIN_LEN);
            h2 ^= rotl(secondary_words[oldest], WIN_LEN);
            for (int i = 0; i < WIN_LEN - 1; i++) win_bytes[i] = win_bytes[i + 1];
            win_bytes[WIN_LEN - 1] = b;
         end else begin
            win_bytes[held] = b;
            held++;
         end
         primary_hash   = h1;
         secondary_hash = h2;
         if (next_offset != OFFSET_MAX) next_offset++;
         if (held >= WIN_LEN) begin
            r.start     = (here >= START_LAG) ? here - START_LAG : 32'd0;
            r.primary   = h1;
            r.secondary = h2;
            r.anchor    = ((h1 & mask) == 64'd0);
            r.last      = eos;
            pending_windows = {pending_windows, r};
         end
         if (eos) restart();
      endfunction

      function void check_window(window_result_type got);
         window_result_type want;
         if (pending_windows.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: start %h primary %h secondary %h",
                        got.start, got.primary, got.secondary);
            return;
         end
         want = pending_windows.pop_front();
         if (got.start !== want.start || got.primary !== want.primary ||
             got.secondary !== want.secondary || got.anchor !== want.anchor ||
             got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected start %h primary %h secondary %h anchor %b final %b",
                        want.start, want.primary, want.secondary, want.anchor, want.last);
               $display("          actual   start %h primary %h secondary %h anchor %b final %b",
                        got.start, got.primary, got.secondary, got.anchor, got.last);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_window_start;
   logic [63:0] rsp_hash_primary;
   logic [63:0] rsp_hash_secondary;
   logic        rsp_is_anchor;
   logic        rsp_final_window;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_anchor_mask;

   anchor_window_predictor anchor_pred;
   bit                     idle_on;
   int                     results_seen;
   logic [63:0]            mask_list [7];

   dual_rolling_hash_anchor_finder_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_stream  (req_end_of_stream),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_start   (rsp_window_start),
      .rsp_hash_primary   (rsp_hash_primary),
      .rsp_hash_secondary (rsp_hash_secondary),
      .rsp_is_anchor      (rsp_is_anchor),
      .rsp_final_window   (rsp_final_window),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_anchor_mask    (csr_anchor_mask)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eos);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      anchor_pred.take_byte(b, eos);
   endtask

   // stop offering, wait for every window to come back, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (anchor_pred.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_anchor_mask(input logic [63:0] m);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_anchor_mask <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      anchor_pred.set_mask(m);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_streams(input int n_items);
      int         sent;
      int         len;
      int         kind;
      bit         solid;
      logic [7:0] run_byte;
      logic [7:0] b;
      logic       eos;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         if (kind < 65) len = $urandom_range(33, 120);
         else if (kind < 78) len = $urandom_range(31, 33);
         else if (kind < 86) len = $urandom_range(1, 30);
         else if (kind < 94) len = $urandom_range(150, 300);
         else len = $urandom_range(1, 40);
         solid    = ($urandom_range(0, 9) == 0);
         run_byte = 8'($urandom);
         for (int i = 0; i < len; i++) begin
            b = solid ? run_byte : 8'($urandom);
            // noise: end flags land anywhere
            if (kind >= 94) eos = ($urandom_range(0, 7) == 0);
            else eos = (i == len - 1);
            send_byte(b, eos);
         end
         sent += len;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         anchor_pred.check_window({rsp_window_start, rsp_hash_primary, rsp_hash_secondary,
                                   rsp_is_anchor, rsp_final_window});
         results_seen++;
      end
   end

   initial begin
      int stall_left;
      bit long_done;
      stall_left = 0;
      long_done  = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         // one long hold-off while the sender keeps pushing
         if (!long_done && results_seen >= 400 && req_valid) begin
            long_done  = 1'b1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [7:0] pattern [4];
      anchor_pred  = new();
      results_seen = 0;
      idle_on      = 1'b1;
      pattern      = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      mask_list    = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'h8000_0000_0000_0000,
                       64'hF, {$urandom, $urandom}, 64'd63};
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= 8'h00;
      req_end_of_stream <= 1'b0;
      csr_valid         <= 1'b0;
      csr_anchor_mask   <= 64'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // streams that end before the window fills, then a run of extreme bytes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      for (int i = 0; i < 20; i++) send_byte(pattern[i % 4], 1'b0);
      run_streams(170);
      settle();

      for (int p = 0; p < 7; p++) begin
         write_anchor_mask(mask_list[p]);
         idle_on = (p % 3 != 1);
         run_streams(165);
         settle();
      end

      if (anchor_pred.errors == 0 && anchor_pred.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/drhaf_pkg.sv
rtl/drhaf_roll.sv
rtl/dual_rolling_hash_anchor_finder_top.sv
rtl/drhaf_checker.sv
tb/sv/dual_rolling_hash_anchor_finder_top_tb.sv
